### rtl/swm_pkg.sv
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int SIZE_W   = 7;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   // one link of the cell chain: running minimum and whether it is complete
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] win_min;
   } link_type;

endpackage

### rtl/swm_if.sv
interface swm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::SAMPLE_W-1:0] sample;
   logic                                last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface swm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [swm_pkg::SAMPLE_W-1:0] window_min;
   logic                                last_result;

   modport source (output valid, output window_min, output last_result, input ready);
   modport sink (input valid, input window_min, input last_result, output ready);
endinterface

interface swm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [swm_pkg::SIZE_W-1:0]  window_size;

   modport source (output valid, output window_size, input ready);
   modport sink (input valid, input window_size, output ready);
endinterface

### rtl/swm_cell.sv
module swm_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                clear,
   input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
   input  swm_pkg::link_type                   left,
   output swm_pkg::link_type                   cell_out,
   output swm_pkg::link_type                   cell_nxt
);

   logic                                valid_ff;
   logic                                valid_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] min_ff;

   // minimum over this cell's span, the new sample included
   always_comb begin
      cell_nxt.valid   = left.valid;
      cell_nxt.win_min = (left.valid && (left.win_min < sample)) ? left.win_min : sample;
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = left.valid && !clear;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         min_ff <= cell_nxt.win_min;
      end
   end

   assign cell_out.valid   = valid_ff;
   assign cell_out.win_min = min_ff;

endmodule

### rtl/sliding_window_minimum.sv
// result: an accepted sample's minimum is in the output register in the next cycle
// throughput: one item per cycle while no result waits unread; each cell of the chain updates once per item
// result register doubles as skid: input stalls only while a result waits unread
// reset: chain empties, window size returns to 1, no result pending
module sliding_window_minimum #(
   parameter int MAX_WINDOW = 64
) (
   input  logic              clock,
   input  logic              reset,
   swm_req_if.sink           req_if,
   swm_rsp_if.source         rsp_if,
   swm_csr_if.sink           csr_if
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int MW_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = (MW_W > swm_pkg::SIZE_W) ? MW_W : swm_pkg::SIZE_W;

   logic                 req_fire;
   logic                 rsp_fire;
   logic [CMP_W-1:0]     size_ext;
   logic [CMP_W-1:0]     size_eff;
   logic [IDX_W-1:0]     window_sel_ff;
   logic [IDX_W-1:0]     window_sel_in;

   swm_pkg::link_type    link [MAX_WINDOW+1];
   swm_pkg::link_type    nxt  [MAX_WINDOW];
   swm_pkg::link_type    pick;
   logic [MAX_WINDOW-1:0] valid_vec;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic signed [swm_pkg::SAMPLE_W-1:0] rsp_min_ff;
   logic                                rsp_last_ff;

   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_valid_ff && rsp_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   // window size clamped to 1..MAX_WINDOW, kept as a cell index
   always_comb begin
      size_ext = CMP_W'(csr_if.window_size);
      size_eff = size_ext;
      if (size_ext == '0) begin
         size_eff = CMP_W'(1);
      end else if (size_ext > CMP_W'(MAX_WINDOW)) begin
         size_eff = CMP_W'(MAX_WINDOW);
      end
      window_sel_in = window_sel_ff;
      if (csr_if.valid) begin
         window_sel_in = IDX_W'(size_eff - CMP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_sel_ff <= '0;
      end else begin
         window_sel_ff <= window_sel_in;
      end
   end

   // chain head acts as an always complete, neutral span
   assign link[0].valid   = 1'b1;
   assign link[0].win_min = swm_pkg::SAMPLE_MAX;

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      swm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .accept   (req_fire),
         .clear    (req_if.last_sample),
         .sample   (req_if.sample),
         .left     (link[k]),
         .cell_out (link[k+1]),
         .cell_nxt (nxt[k])
      );
      assign valid_vec[k] = link[k+1].valid;
   end

   assign pick = nxt[window_sel_ff];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = pick.valid;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_min_ff  <= pick.win_min;
         rsp_last_ff <= req_if.last_sample;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.window_min  = rsp_min_ff;
   assign rsp_if.last_result = rsp_last_ff;

   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("cell valid bits not contiguous");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.last_sample |=> valid_vec == '0)
      else $error("chain not emptied after last item");

   a_unit_window: assert property (@(posedge clock) disable iff (reset)
      req_fire && (window_sel_ff == '0) |=>
         rsp_valid_ff && (rsp_min_ff == $past(req_if.sample)))
      else $error("window of one must echo the sample");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_valid_ff && !rsp_if.ready)
      else $error("input stalled without a waiting result");

endmodule

### test/sliding_window_minimum_tb.sv
module sliding_window_minimum_tb;

   localparam int WIN_DEPTH      = 64;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int TIMEOUT_CYCLES = 400000;

   localparam logic signed [swm_pkg::SAMPLE_W-1:0] SAMPLE_MIN = ~swm_pkg::SAMPLE_MAX;

   typedef struct {
      logic signed [swm_pkg::SAMPLE_W-1:0] smp;
      logic                                lst;
   } sample_item_type;

   typedef struct {
      logic signed [swm_pkg::SAMPLE_W-1:0] lo;
      logic                                lst;
   } window_result_type;

   logic clock;
   logic reset;

   swm_req_if req_if ();
   swm_rsp_if rsp_if ();
   swm_csr_if csr_if ();

   sliding_window_minimum #(
      .MAX_WINDOW(WIN_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   sample_item_type   pending_items[$];
   window_result_type min_queue[$];
   window_result_type want;

   // window tracking state
   logic signed [swm_pkg::SAMPLE_W-1:0] win_store [WIN_DEPTH];
   logic [5:0]                          wr_pos;
   logic [swm_pkg::SIZE_W-1:0]          fill_cnt;
   logic [swm_pkg::SIZE_W-1:0]          size_reg;

   int  queued_count  = 0;
   int  samples_taken = 0;
   int  minima_checked = 0;
   int  fail_count    = 0;
   int  settings_used = 0;
   int  send_gap;
   int  take_wait;
   int  stall_draw;
   bit  send_idle;
   bit  take_idle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 12);
      $display("%0t: timeout with %0d minima outstanding", $time, min_queue.size());
      $display("sliding_window_minimum_tb NOT OK");
      $finish;
   end

   function automatic int pause_cycles(input bit idle_on);
      return idle_on ? $urandom_range(0, 13) : 0;
   endfunction

   task automatic track_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] s, input logic lst);
      int                                  eff;
      logic signed [swm_pkg::SAMPLE_W-1:0] lo;
      logic [5:0]                          idx;
      eff = (size_reg == 0) ? 1 : ((size_reg > WIN_DEPTH) ? WIN_DEPTH : int'(size_reg));
      win_store[wr_pos] = s;
      wr_pos = wr_pos + 6'd1;
      if (fill_cnt < WIN_DEPTH) fill_cnt = fill_cnt + 7'd1;
      if (fill_cnt >= eff) begin
         lo  = s;
         idx = wr_pos;
         for (int k = 0; k < eff; k++) begin
            idx = idx - 6'd1;
            if (win_store[idx] < lo) lo = win_store[idx];
         end
         min_queue.push_back('{lo, lst});
      end
      if (lst) begin
         fill_cnt = '0;
         wr_pos   = '0;
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (pending_items.size() != 0) begin
            req_if.valid       <= 1'b1;
            req_if.sample      <= pending_items[0].smp;
            req_if.last_sample <= pending_items[0].lst;
            pending_items.pop_front();
            send_gap <= pause_cycles(send_idle);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait    <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         stall_draw = pause_cycles(take_idle);
         take_wait    <= stall_draw;
         rsp_if.ready <= (stall_draw == 0);
      end else if (take_wait != 0) begin
         take_wait    <= take_wait - 1;
         rsp_if.ready <= (take_wait == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         size_reg = 7'd1;
         fill_cnt = '0;
         wr_pos   = '0;
      end else begin
         if (csr_if.valid && csr_if.ready) size_reg = csr_if.window_size;
         if (req_if.valid && req_if.ready) begin
            track_sample(req_if.sample, req_if.last_sample);
            samples_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (min_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, got min %0d last %0b",
                        $time, rsp_if.window_min, rsp_if.last_result);
               fail_count++;
            end else begin
               want = min_queue.pop_front();
               minima_checked++;
               if (rsp_if.window_min !== want.lo) begin
                  $display("%0t: window_min expected %0d got %0d",
                           $time, want.lo, rsp_if.window_min);
                  fail_count++;
               end
               if (rsp_if.last_result !== want.lst) begin
                  $display("%0t: last_result expected %0b got %0b",
                           $time, want.lst, rsp_if.last_result);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic queue_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] s, input logic lst);
      pending_items.push_back('{s, lst});
      queued_count++;
   endtask

   task automatic settle();
      while (samples_taken != queued_count || min_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_window(input logic [swm_pkg::SIZE_W-1:0] v);
      settle();
      csr_if.valid       <= 1'b1;
      csr_if.window_size <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [swm_pkg::SAMPLE_W-1:0] pick_sample(
      input int style, input int pos, input logic signed [swm_pkg::SAMPLE_W-1:0] base);
      case (style)
         1: return int'($urandom_range(0, 16)) - 8;
         2: return base + pos;
         3: return base - pos;
         4: begin
            case ($urandom_range(0, 3))
               0: return swm_pkg::SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int                                  eff;
      int                                  n_seq;
      int                                  len;
      int                                  style;
      bit                                  closes;
      logic [swm_pkg::SIZE_W-1:0]          wsize;
      logic signed [swm_pkg::SAMPLE_W-1:0] base;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.sample      = '0;
      req_if.last_sample = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.window_size = '0;
      send_idle          = 1'b1;
      take_idle          = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // window of one: every sample is its own minimum
      set_window(7'd1);
      queue_sample(swm_pkg::SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(-1, 1'b0);
      queue_sample(1, 1'b1);

      // window of three, then a short sequence that never fills
      set_window(7'd3);
      queue_sample(5, 1'b0);
      queue_sample(-7, 1'b0);
      queue_sample(2, 1'b0);
      queue_sample(9, 1'b0);
      queue_sample(10, 1'b1);
      queue_sample(3, 1'b1);
      queue_sample(1, 1'b0);
      queue_sample(2, 1'b0);
      queue_sample(3, 1'b1);

      // size zero acts as one
      set_window(7'd0);
      queue_sample(32'hAAAA_AAAA, 1'b0);
      queue_sample(32'h5555_5555, 1'b1);

      // size grows in mid-sequence
      set_window(7'd2);
      queue_sample(4, 1'b0);
      queue_sample(8, 1'b0);
      set_window(7'd4);
      queue_sample(1, 1'b0);
      queue_sample(6, 1'b1);

      while (queued_count < 20 + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: wsize = 7'd0;
            1: wsize = 7'd64;
            2: wsize = 7'd127;
            3: wsize = 7'($urandom_range(65, 126));
            4: wsize = 7'($urandom_range(9, 63));
            default: wsize = 7'($urandom_range(1, 8));
         endcase
         set_window(wsize);
         eff = (wsize == 0) ? 1 : ((wsize > WIN_DEPTH) ? WIN_DEPTH : int'(wsize));
         {take_idle, send_idle} = 2'($urandom_range(0, 3));
         n_seq = (eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
         for (int q = 0; q < n_seq; q++) begin
            if ($urandom_range(0, 5) == 0) len = $urandom_range(1, eff);
            else len = $urandom_range(eff, 2 * eff + 8);
            style  = $urandom_range(0, 4);
            base   = $urandom;
            // an open sequence carries over into the next window setting
            closes = (q != n_seq - 1) || ($urandom_range(0, 3) != 0);
            for (int p = 0; p < len; p++) begin
               queue_sample(pick_sample(style, p, base), closes && (p == len - 1));
            end
         end
      end

      settle();
      repeat (4) @(posedge clock);
      $display("covered %0d samples and %0d checked minima over %0d window settings",
               samples_taken, minima_checked, settings_used);
      $display("window sizes ran from zero through saturation, with mixed idle and stall");
      if (fail_count == 0) begin
         $display("sliding_window_minimum_tb OK");
      end else begin
         $display("sliding_window_minimum_tb NOT OK");
      end
      $finish;
   end

endmodule
